// File: src/overlapping_circle_merger_top_macros.svh
// Assertion macros for the overlapping circle merger.
// Included by overlapping_circle_merger_top; no other dependencies.
`ifndef OVERLAPPING_CIRCLE_MERGER_TOP_MACROS_SVH
`define OVERLAPPING_CIRCLE_MERGER_TOP_MACROS_SVH

// check a consequence in the same cycle
`define OCM_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ocm: same-cycle check failed");

// check a consequence in the next cycle
`define OCM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ocm: next-cycle check failed");

`endif

// File: src/ocm_pkg.sv
// Shared constants for the overlapping circle merger.
// No dependencies; used by overlapping_circle_merger_top.
package ocm_pkg;

   localparam int FIELD_BITS      = 12;
   localparam int COUNT_BITS      = 7;
   localparam int MAX_CIRCLES_DEF = 64;
   localparam int COORD_BITS_DEF  = 12;
   localparam int DIST_SCALE      = 400;
   localparam int RAD_SCALE       = 529;

endpackage

// File: src/overlapping_circle_merger_top.sv
// Overlapping circle merger: load a list of circles, merge close ones, emit survivors.
// Depends on ocm_pkg and overlapping_circle_merger_top_macros.svh.
//
// Usage:
//   Input beats are taken at a clock edge with start high and busy low. A beat
//   without req_list_end is stored and busy stays low, so a list loads at
//   one circle per cycle. Circles beyond MAX_CIRCLES are dropped and flagged
//   on every result of that list.
//   A beat with req_list_end raises busy for the merge and emit passes. The
//   merge reads the circle store (one read port, one write port) once per
//   pair; the single read port feeds a pipelined distance compare.
//   The emit pass then reads each stored entry in turn; each survivor appears
//   as one result beat, rsp_strobe high for exactly one cycle, the last with
//   rsp_last_of_run. The first result follows list_end after roughly the
//   merge time; busy drops with the last scanned entry.
//   The receiver cannot stall: results are presented once and not held.
//   Reset clears the control state and the list; no clearing pass is needed.
module overlapping_circle_merger_top #(
   parameter int MAX_CIRCLES = ocm_pkg::MAX_CIRCLES_DEF,
   parameter int COORD_BITS  = ocm_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ocm_pkg::FIELD_BITS-1:0]   req_center_x,
   input  logic [ocm_pkg::FIELD_BITS-1:0]   req_center_y,
   input  logic [ocm_pkg::FIELD_BITS-1:0]   req_circle_radius,
   input  logic                             req_list_end,
   output logic                             rsp_strobe,
   output logic [ocm_pkg::FIELD_BITS-1:0]   rsp_merged_x,
   output logic [ocm_pkg::FIELD_BITS-1:0]   rsp_merged_y,
   output logic [ocm_pkg::FIELD_BITS-1:0]   rsp_merged_radius,
   output logic                             rsp_last_of_run,
   output logic [ocm_pkg::COUNT_BITS-1:0]   rsp_survivor_count,
   output logic                             rsp_overflow_flag
);

   `include "overlapping_circle_merger_top_macros.svh"

   localparam int FB = ocm_pkg::FIELD_BITS;
   localparam int SB = ocm_pkg::COUNT_BITS;
   localparam int C  = COORD_BITS;
   localparam int AW = $clog2(MAX_CIRCLES);
   localparam int CW = $clog2(MAX_CIRCLES + 1);
   localparam int PW = 2 * C;
   localparam int LW = 2 * C + 10;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RDI   = 3'd1;
   localparam logic [2:0] ST_WTI   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_ERD   = 3'd5;
   localparam logic [2:0] ST_EWT   = 3'd6;

   typedef struct packed {
      logic         alive;
      logic [C-1:0] x;
      logic [C-1:0] y;
      logic [C-1:0] r;
   } entry_type;

   typedef struct packed {
      logic [AW-1:0] idx;
      logic [C-1:0]  x;
      logic [C-1:0]  y;
      logic [C-1:0]  r;
   } cand_type;

   entry_type store_mem [MAX_CIRCLES];
   entry_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          we;
   logic [AW-1:0] wa;
   entry_type     wd;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, e_ff, e_in;
   logic [CW-1:0] loaded_ff, loaded_in, surv_ff, surv_in, emit_ff, emit_in;
   logic          dropped_ff, dropped_in;
   entry_type     orig_ff, orig_in, new_ff, new_in;
   logic          issue;

   logic          v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AW-1:0] j1_ff;
   cand_type      cand2_ff, cand3_ff, cand4_ff;
   logic [C-1:0]  dx_ff, dy_ff, h_ff;
   logic [PW-1:0] sqx_ff, sqy_ff, sqh_ff;
   logic [LW-1:0] lhs_ff, rhs_ff;
   logic [C-1:0]  dx_c, dy_c;
   logic [C:0]    hsum_c, avgx_c, avgy_c, avgr_c;
   logic          kill_we, pipe_busy, accept;

   logic          strobe_ff, strobe_in, last_ff, last_in;
   logic [FB-1:0] ox_ff, oy_ff, or_ff;
   logic [SB-1:0] cnt_ff;
   logic          ovf_ff;

   logic [FB+C-1:0]  in_x_ext, in_y_ext, in_r_ext;
   logic [FB+C-1:0]  out_x_ext, out_y_ext, out_r_ext;
   logic [SB+CW-1:0] cnt_ext;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign kill_we   = v4_ff && (lhs_ff < rhs_ff);

   assign in_x_ext  = {{C{1'b0}}, req_center_x};
   assign in_y_ext  = {{C{1'b0}}, req_center_y};
   assign in_r_ext  = {{C{1'b0}}, req_circle_radius};
   assign out_x_ext = {{FB{1'b0}}, rd_data_ff.x};
   assign out_y_ext = {{FB{1'b0}}, rd_data_ff.y};
   assign out_r_ext = {{FB{1'b0}}, rd_data_ff.r};
   assign cnt_ext   = {{SB{1'b0}}, surv_ff};

   assign dx_c   = (orig_ff.x > rd_data_ff.x) ? (orig_ff.x - rd_data_ff.x)
                                              : (rd_data_ff.x - orig_ff.x);
   assign dy_c   = (orig_ff.y > rd_data_ff.y) ? (orig_ff.y - rd_data_ff.y)
                                              : (rd_data_ff.y - orig_ff.y);
   assign hsum_c = {1'b0, orig_ff.r} + {1'b0, rd_data_ff.r};
   assign avgx_c = {1'b0, orig_ff.x} + {1'b0, cand4_ff.x};
   assign avgy_c = {1'b0, orig_ff.y} + {1'b0, cand4_ff.y};
   assign avgr_c = {1'b0, orig_ff.r} + {1'b0, cand4_ff.r};

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      e_in       = e_ff;
      loaded_in  = loaded_ff;
      dropped_in = dropped_ff;
      surv_in    = surv_ff;
      emit_in    = emit_ff;
      orig_in    = orig_ff;
      new_in     = new_ff;
      rd_addr    = '0;
      issue      = 1'b0;
      we         = 1'b0;
      wa         = '0;
      wd         = '0;
      strobe_in  = 1'b0;
      last_in    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (loaded_ff < CW'(MAX_CIRCLES)) begin
                  we        = 1'b1;
                  wa        = loaded_ff[AW-1:0];
                  wd        = '{alive: 1'b1, x: in_x_ext[C-1:0], y: in_y_ext[C-1:0],
                                r: in_r_ext[C-1:0]};
                  loaded_in = loaded_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_list_end) begin
                  state_in = ST_RDI;
                  i_in     = '0;
                  surv_in  = '0;
               end
            end
         end
         ST_RDI: begin
            rd_addr  = i_ff[AW-1:0];
            state_in = ST_WTI;
         end
         ST_WTI: begin
            if (rd_data_ff.alive) begin
               orig_in = rd_data_ff;
               new_in  = rd_data_ff;
               surv_in = surv_ff + CW'(1);
               if (i_ff + CW'(1) == loaded_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  j_in     = i_ff + CW'(1);
                  state_in = ST_SCAN;
               end
            end else begin
               i_in = i_ff + CW'(1);
               if (i_ff + CW'(1) == loaded_ff) begin
                  state_in = ST_ERD;
                  e_in     = '0;
                  emit_in  = '0;
               end else begin
                  state_in = ST_RDI;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = j_ff[AW-1:0];
            issue   = 1'b1;
            j_in    = j_ff + CW'(1);
            if (j_ff + CW'(1) == loaded_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               we       = 1'b1;
               wa       = i_ff[AW-1:0];
               wd       = '{alive: 1'b1, x: new_ff.x, y: new_ff.y, r: new_ff.r};
               i_in     = i_ff + CW'(1);
               if (i_ff + CW'(1) == loaded_ff) begin
                  state_in = ST_ERD;
                  e_in     = '0;
                  emit_in  = '0;
               end else begin
                  state_in = ST_RDI;
               end
            end
         end
         ST_ERD: begin
            rd_addr  = e_ff[AW-1:0];
            state_in = ST_EWT;
         end
         ST_EWT: begin
            if (rd_data_ff.alive) begin
               strobe_in = 1'b1;
               last_in   = (emit_ff + CW'(1) == surv_ff);
               emit_in   = emit_ff + CW'(1);
            end
            e_in = e_ff + CW'(1);
            if (e_ff + CW'(1) == loaded_ff) begin
               state_in   = ST_IDLE;
               loaded_in  = '0;
               dropped_in = 1'b0;
            end else begin
               state_in = ST_ERD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // drop a close later circle and take the average with it
      if (kill_we) begin
         we     = 1'b1;
         wa     = cand4_ff.idx;
         wd     = '{alive: 1'b0, x: cand4_ff.x, y: cand4_ff.y, r: cand4_ff.r};
         new_in = '{alive: 1'b1, x: avgx_c[C:1], y: avgy_c[C:1], r: avgr_c[C:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[wa] <= wd;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         i_ff       <= '0;
         j_ff       <= '0;
         e_ff       <= '0;
         loaded_ff  <= '0;
         dropped_ff <= 1'b0;
         surv_ff    <= '0;
         emit_ff    <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         e_ff       <= e_in;
         loaded_ff  <= loaded_in;
         dropped_ff <= dropped_in;
         surv_ff    <= surv_in;
         emit_ff    <= emit_in;
         v1_ff      <= issue;
         v2_ff      <= v1_ff && rd_data_ff.alive;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      orig_ff  <= orig_in;
      new_ff   <= new_in;
      j1_ff    <= j_ff[AW-1:0];
      cand2_ff <= '{idx: j1_ff, x: rd_data_ff.x, y: rd_data_ff.y, r: rd_data_ff.r};
      dx_ff    <= dx_c;
      dy_ff    <= dy_c;
      h_ff     <= hsum_c[C:1];
      cand3_ff <= cand2_ff;
      sqx_ff   <= PW'(dx_ff) * PW'(dx_ff);
      sqy_ff   <= PW'(dy_ff) * PW'(dy_ff);
      sqh_ff   <= PW'(h_ff) * PW'(h_ff);
      cand4_ff <= cand3_ff;
      lhs_ff   <= (LW'(sqx_ff) + LW'(sqy_ff)) * LW'(ocm_pkg::DIST_SCALE);
      rhs_ff   <= LW'(sqh_ff) * LW'(ocm_pkg::RAD_SCALE);
      if (strobe_in) begin
         ox_ff   <= out_x_ext[FB-1:0];
         oy_ff   <= out_y_ext[FB-1:0];
         or_ff   <= out_r_ext[FB-1:0];
         last_ff <= last_in;
         cnt_ff  <= cnt_ext[SB-1:0];
         ovf_ff  <= dropped_ff;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_merged_x       = ox_ff;
   assign rsp_merged_y       = oy_ff;
   assign rsp_merged_radius  = or_ff;
   assign rsp_last_of_run    = last_ff;
   assign rsp_survivor_count = cnt_ff;
   assign rsp_overflow_flag  = ovf_ff;

   `OCM_ASSERT_SAME(a_kill_beyond_i, clock, reset, kill_we, cand4_ff.idx > i_ff[AW-1:0])
   `OCM_ASSERT_SAME(a_pipe_empty_on_rdi, clock, reset, state_ff == ST_RDI, !pipe_busy)
   `OCM_ASSERT_SAME(a_emit_bound, clock, reset, strobe_in, emit_ff < surv_ff)
   `OCM_ASSERT_NEXT(a_end_busy, clock, reset, accept && req_list_end, busy)
   `OCM_ASSERT_SAME(a_clear_on_done, clock, reset, $fell(busy), loaded_ff == '0)

endmodule
